FILE: src/sha256_stream_hasher_assert.svh
// ---------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sha_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and round functions of the hasher.
// ---------------------------------------------------------------------------
package sha_pkg;

  localparam int CountW     = 61;
  localparam int QueueDepth = 16;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [3:0]  LenHiPos   = 4'd14;
  localparam logic [5:0]  LastRound  = 6'd63;
  localparam logic [2:0]  DigestLast = 3'd7;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } sha_word_t;

  typedef enum logic [1:0] {
    FR_BYTES,
    FR_PAD,
    FR_FILL,
    FR_LEN_LO
  } sha_front_state_e;

  typedef enum logic [1:0] {
    CR_START,
    CR_ROUND,
    CR_ADD
  } sha_core_state_e;

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: src/sha_front.sv
// ---------------------------------------------------------------------------
// SHA-256 front end
// Packs message bytes into big-endian words, counts the message length and
// appends the padding and length words after the final byte.
// ---------------------------------------------------------------------------
module sha_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sha_pkg::sha_in_t   item_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sha_pkg::sha_word_t q_entry_o
);

  sha_pkg::sha_front_state_e state_q, state_d;
  logic [sha_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [23:0] acc_q, acc_d;
  logic [1:0]  lane_q, lane_d;
  logic [3:0]  wpos_q, wpos_d;
  logic [63:0] bit_len;
  logic        accept;

  assign full    = q_full_i || (state_q != sha_pkg::FR_BYTES);
  assign accept  = push && !full;
  assign bit_len = {cnt_q, 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::FR_BYTES;
      cnt_q   <= '0;
      lane_q  <= '0;
      wpos_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lane_q  <= lane_d;
      wpos_q  <= wpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    lane_d    = lane_q;
    wpos_d    = wpos_q;
    q_push_o  = 1'b0;
    q_entry_o = '{word: '0, last: 1'b0};
    case (state_q)
      sha_pkg::FR_BYTES: begin
        if (accept) begin
          cnt_d = cnt_q + 1'b1;
          if (lane_q == 2'd3) begin
            q_push_o       = 1'b1;
            q_entry_o.word = {acc_q, item_i.data_byte};
            wpos_d         = wpos_q + 1'b1;
            lane_d         = '0;
          end else begin
            acc_d  = {acc_q[15:0], item_i.data_byte};
            lane_d = lane_q + 1'b1;
          end
          if (item_i.end_of_message) begin
            state_d = sha_pkg::FR_PAD;
          end
        end
      end
      sha_pkg::FR_PAD: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          case (lane_q)
            2'd1:    q_entry_o.word = {acc_q[7:0], sha_pkg::PadByte, 16'h0000};
            2'd2:    q_entry_o.word = {acc_q[15:0], sha_pkg::PadByte, 8'h00};
            2'd3:    q_entry_o.word = {acc_q, sha_pkg::PadByte};
            default: q_entry_o.word = {sha_pkg::PadByte, 24'h000000};
          endcase
          lane_d  = '0;
          wpos_d  = wpos_q + 1'b1;
          state_d = sha_pkg::FR_FILL;
        end
      end
      sha_pkg::FR_FILL: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          wpos_d   = wpos_q + 1'b1;
          if (wpos_q == sha_pkg::LenHiPos) begin
            q_entry_o.word = bit_len[63:32];
            state_d        = sha_pkg::FR_LEN_LO;
          end
        end
      end
      sha_pkg::FR_LEN_LO: begin
        if (!q_full_i) begin
          q_push_o       = 1'b1;
          q_entry_o.word = bit_len[31:0];
          q_entry_o.last = 1'b1;
          wpos_d         = wpos_q + 1'b1;
          cnt_d          = '0;
          state_d        = sha_pkg::FR_BYTES;
        end
      end
      default: begin
        state_d = sha_pkg::FR_BYTES;
      end
    endcase
  end

endmodule

FILE: src/sha_fifo.sv
// ---------------------------------------------------------------------------
// SHA-256 word queue
// Short first-in first-out queue of message words between front and core.
// ---------------------------------------------------------------------------
module sha_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha_pkg::sha_word_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output sha_pkg::sha_word_t rdata_o,
  output logic               empty_o
);

  sha_pkg::sha_word_t mem_q [sha_pkg::QueueDepth];
  logic [sha_pkg::QueuePtrW-1:0] wptr_q, rptr_q;
  logic [sha_pkg::QueuePtrW:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (sha_pkg::QueuePtrW + 1)'(sha_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/sha_core.sv
// ---------------------------------------------------------------------------
// SHA-256 compression core
// Runs one round per cycle (stalled by an empty queue in rounds 0-15), keeps
// the chaining words and holds the finished digest until all eight are taken.
// ---------------------------------------------------------------------------
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::sha_word_t q_entry_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output sha_pkg::sha_out_t  result_o
);

  sha_pkg::sha_core_state_e state_q, state_d;
  logic [5:0]  t_q, t_d;
  logic        last_blk_q, last_blk_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic [31:0] h_q [8];
  logic [31:0] h_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] dig_q [8];
  logic [31:0] dig_d [8];
  logic [31:0] sched, w_cur, t1, t2;
  logic        advance;

  assign empty                = !out_valid_q;
  assign result_o.digest_word = dig_q[out_idx_q];
  assign result_o.word_index  = out_idx_q;
  assign result_o.last_word   = (out_idx_q == sha_pkg::DigestLast);

  assign sched = sha_pkg::small_s1(w_q[14]) + w_q[9] + sha_pkg::small_s0(w_q[1]) + w_q[0];
  assign w_cur = (t_q[5:4] == 2'b00) ? q_entry_i.word : sched;
  assign t1 = v_q[7] + sha_pkg::big_s1(v_q[4]) + sha_pkg::choose(v_q[4], v_q[5], v_q[6])
            + sha_pkg::ROUND_K[t_q] + w_cur;
  assign t2 = sha_pkg::big_s0(v_q[0]) + sha_pkg::majority(v_q[0], v_q[1], v_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha_pkg::CR_START;
      t_q         <= '0;
      last_blk_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_pkg::INIT_H[i];
      end
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      last_blk_q  <= last_blk_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      h_q         <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    w_q   <= w_d;
    dig_q <= dig_d;
  end

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    last_blk_d  = last_blk_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    h_d         = h_q;
    v_d         = v_q;
    w_d         = w_q;
    dig_d       = dig_q;
    q_pop_o     = 1'b0;
    advance     = 1'b0;

    if (out_valid_q && pop) begin
      out_idx_d = out_idx_q + 1'b1;
      if (out_idx_q == sha_pkg::DigestLast) begin
        out_valid_d = 1'b0;
      end
    end

    case (state_q)
      sha_pkg::CR_START: begin
        v_d     = h_q;
        t_d     = '0;
        state_d = sha_pkg::CR_ROUND;
      end
      sha_pkg::CR_ROUND: begin
        if (t_q[5:4] == 2'b00) begin
          q_pop_o = !q_empty_i;
          advance = !q_empty_i;
          if (t_q[3:0] == 4'hf) begin
            last_blk_d = q_entry_i.last;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          for (int i = 0; i < 15; i++) begin
            w_d[i] = w_q[i+1];
          end
          w_d[15] = w_cur;
          v_d[7] = v_q[6];
          v_d[6] = v_q[5];
          v_d[5] = v_q[4];
          v_d[4] = v_q[3] + t1;
          v_d[3] = v_q[2];
          v_d[2] = v_q[1];
          v_d[1] = v_q[0];
          v_d[0] = t1 + t2;
          t_d    = t_q + 1'b1;
          if (t_q == sha_pkg::LastRound) begin
            state_d = sha_pkg::CR_ADD;
          end
        end
      end
      sha_pkg::CR_ADD: begin
        if (!last_blk_q) begin
          for (int i = 0; i < 8; i++) begin
            h_d[i] = h_q[i] + v_q[i];
          end
          state_d = sha_pkg::CR_START;
        end else if (!out_valid_q) begin
          for (int i = 0; i < 8; i++) begin
            dig_d[i] = h_q[i] + v_q[i];
            h_d[i]   = sha_pkg::INIT_H[i];
          end
          out_valid_d = 1'b1;
          out_idx_d   = '0;
          last_blk_d  = 1'b0;
          state_d     = sha_pkg::CR_START;
        end
      end
      default: begin
        state_d = sha_pkg::CR_START;
      end
    endcase
  end

endmodule

FILE: src/sha256_stream_hasher.sv
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns each digest as eight 32-bit words.
// ---------------------------------------------------------------------------
// The block takes one message byte per item, at most one a cycle and only
// while full is low, and marks the final byte with end_of_message. For each
// 64-byte block the compression core runs a load step, 64 rounds at one
// round a cycle unless the queue runs empty, and an add step; a sixteen-word
// queue lets the byte packer run ahead by one block. After the final byte
// the packer is busy writing padding and the length, and stalls while the
// queue is full; the core then finishes one or two more blocks, and the
// eight digest words appear on the result side, first word first. A new
// message may start at once; its digest waits in the core until the
// previous one has been taken.
module sha256_stream_hasher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  sha_pkg::sha_in_t  item_i,
  output logic              empty,
  input  logic              pop,
  output sha_pkg::sha_out_t result_o
);

  `include "sha256_stream_hasher_assert.svh"

  sha_pkg::sha_word_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_empty;

  sha_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .item_i    (item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_wdata)
  );

  sha_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  sha_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_entry_i (q_rdata),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

  `SHA_ASSERT_SAME(a_no_push_when_full, q_push, !q_full, "word pushed into a full queue")
  `SHA_ASSERT_SAME(a_no_pop_when_empty, q_pop, !q_empty, "word popped from an empty queue")
  `SHA_ASSERT_NEXT(a_pad_blocks_input, push && !full && item_i.end_of_message, full,
                   "input taken while padding")
  `SHA_ASSERT_NEXT(a_digest_drains, pop && !empty && result_o.last_word, empty,
                   "digest still shown after its last word")

endmodule
